### sv/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg: shared types, constants and helpers for the text line splitter
// Command format between front and back, code-unit matching helpers.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int UNIT_BITS   = 32;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CFG_BITS    = 3;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Register indexes on the config port
  localparam logic CFG_UNIT_BYTES = 1'b0;
  localparam logic CFG_BIG_ENDIAN = 1'b1;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,  // no CR held
    PH_CR   = 2'd1,  // one CR held
    PH_CRCR = 2'd2   // CR CR held
  } phase_e;

  // What one result slot of a command produces
  typedef enum logic [2:0] {
    K_NONE,      // no unit, no line end (bare end of stream)
    K_CR,        // CR inside a line
    K_CR_END,    // CR closing a line, length from command
    K_CR_END1,   // lone CR line, length 1
    K_UNIT,      // plain unit
    K_UNIT_END,  // unit (LF) closing a line, length from command
    K_CLOSE      // no unit, closes open line at end of stream
  } kind_e;

  typedef struct packed {
    logic [UNIT_BITS-1:0] unit_mask;
    logic [UNIT_BITS-1:0] cr;
    logic [UNIT_BITS-1:0] lf;
  } match_t;

  typedef struct packed {
    kind_e [MAX_RESULTS-1:0] kind;
    logic  [1:0]             cnt;   // results in this command, 0..3 (0 is never pushed)
    logic  [UNIT_BITS-1:0]   unit;
    logic  [LENGTH_BITS-1:0] len;
    logic                    eos;
  } cmd_t;

  typedef struct packed {
    logic                    has_unit;
    logic [UNIT_BITS-1:0]    unit;
    logic                    line_end;
    logic [LENGTH_BITS-1:0]  len;
    logic                    stream_end;
    logic                    last;
  } result_t;

  function automatic logic [UNIT_BITS-1:0] unit_mask(logic [CFG_BITS-1:0] ub);
    logic [UNIT_BITS-1:0] m;
    case (ub)
      3'd1:    m = UNIT_BITS'(32'h0000_00FF);
      3'd2:    m = UNIT_BITS'(32'h0000_FFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [UNIT_BITS-1:0] char_code(logic [CFG_BITS-1:0] ub,
                                                     logic be, logic [7:0] ch);
    logic [UNIT_BITS-1:0] c;
    c = UNIT_BITS'(ch);
    if (be) begin
      case (ub)
        3'd1:    c = c;
        3'd2:    c = c << 8;
        default: c = c << 24;
      endcase
    end
    return c;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_sat_add(logic [LENGTH_BITS-1:0] a,
                                                         logic [1:0] b);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + (LENGTH_BITS+1)'(b);
    return s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
  endfunction

endpackage

### sv/tls_front.sv
// ----------------------------------------------------------------------------
// tls_front: input classifier
// Matches CR/LF, tracks held CRs and line length, emits one command per item that yields results.
// ----------------------------------------------------------------------------
module tls_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic                            action_i,
  input  logic [tls_pkg::UNIT_BITS-1:0]   code_unit_i,
  input  tls_pkg::match_t                 match_i,
  input  logic                            full_i,
  output logic                            push_o,
  output tls_pkg::cmd_t                   cmd_o
);

  tls_pkg::phase_e                      phase_q, phase_d, ph;
  logic [tls_pkg::LENGTH_BITS-1:0]      count_q, count_d;
  logic                                 open_q, open_d;
  logic [tls_pkg::UNIT_BITS-1:0]        u;
  logic                                 is_cr, is_lf, acc;

  assign ready_o = !full_i;
  assign acc     = valid_i && !full_i;
  assign push_o  = acc && (cmd_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tls_pkg::PH_NONE;
      count_q <= '0;
      open_q  <= 1'b0;
    end else if (acc) begin
      phase_q <= phase_d;
      count_q <= count_d;
      open_q  <= open_d;
    end
  end

  always_comb begin
    u     = code_unit_i & match_i.unit_mask;
    is_cr = (u == match_i.cr);
    is_lf = (u == match_i.lf);

    case (phase_q)
      tls_pkg::PH_CR, tls_pkg::PH_CRCR: ph = phase_q;
      default:                          ph = tls_pkg::PH_NONE;
    endcase

    phase_d = ph;
    count_d = count_q;
    open_d  = open_q;

    cmd_o      = '0;
    cmd_o.kind = {tls_pkg::K_NONE, tls_pkg::K_NONE, tls_pkg::K_NONE};
    cmd_o.unit = u;

    if (action_i) begin
      // end of stream: flush held CRs or the open line
      cmd_o.eos = 1'b1;
      cmd_o.cnt = 2'd1;
      if (ph != tls_pkg::PH_NONE) begin
        cmd_o.kind[0] = tls_pkg::K_CR_END;
        cmd_o.len     = tls_pkg::len_sat_add(count_q, 2'd1);
        if (ph == tls_pkg::PH_CRCR) begin
          cmd_o.kind[1] = tls_pkg::K_CR_END1;
          cmd_o.cnt     = 2'd2;
        end
      end else if (open_q) begin
        cmd_o.kind[0] = tls_pkg::K_CLOSE;
        cmd_o.len     = count_q;
      end
      phase_d = tls_pkg::PH_NONE;
      count_d = '0;
      open_d  = 1'b0;
    end else if (ph == tls_pkg::PH_NONE) begin
      if (is_lf) begin
        cmd_o.kind[0] = tls_pkg::K_UNIT_END;
        cmd_o.cnt     = 2'd1;
        cmd_o.len     = tls_pkg::len_sat_add(count_q, 2'd1);
        count_d       = '0;
        open_d        = 1'b0;
      end else if (is_cr) begin
        phase_d = tls_pkg::PH_CR;
      end else begin
        cmd_o.kind[0] = tls_pkg::K_UNIT;
        cmd_o.cnt     = 2'd1;
        count_d       = tls_pkg::len_sat_add(count_q, 2'd1);
        open_d        = 1'b1;
      end
    end else if (is_lf) begin
      // CR LF or CR CR LF: held CRs stay in the line
      cmd_o.kind[0] = tls_pkg::K_CR;
      if (ph == tls_pkg::PH_CRCR) begin
        cmd_o.kind[1] = tls_pkg::K_CR;
        cmd_o.kind[2] = tls_pkg::K_UNIT_END;
        cmd_o.cnt     = 2'd3;
        cmd_o.len     = tls_pkg::len_sat_add(count_q, 2'd3);
      end else begin
        cmd_o.kind[1] = tls_pkg::K_UNIT_END;
        cmd_o.cnt     = 2'd2;
        cmd_o.len     = tls_pkg::len_sat_add(count_q, 2'd2);
      end
      phase_d = tls_pkg::PH_NONE;
      count_d = '0;
      open_d  = 1'b0;
    end else if (is_cr && ph == tls_pkg::PH_CR) begin
      phase_d = tls_pkg::PH_CRCR;
    end else begin
      // held CR(s) each end a line, a second one as a lone-CR line
      cmd_o.kind[0] = tls_pkg::K_CR_END;
      cmd_o.len     = tls_pkg::len_sat_add(count_q, 2'd1);
      cmd_o.cnt     = 2'd1;
      if (ph == tls_pkg::PH_CRCR) begin
        cmd_o.kind[1] = tls_pkg::K_CR_END1;
        cmd_o.cnt     = 2'd2;
      end
      if (is_cr) begin
        phase_d = tls_pkg::PH_CR;
        count_d = '0;
        open_d  = 1'b0;
      end else begin
        if (ph == tls_pkg::PH_CRCR) begin
          cmd_o.kind[2] = tls_pkg::K_UNIT;
          cmd_o.cnt     = 2'd3;
        end else begin
          cmd_o.kind[1] = tls_pkg::K_UNIT;
          cmd_o.cnt     = 2'd2;
        end
        phase_d = tls_pkg::PH_NONE;
        count_d = tls_pkg::len_sat_add('0, 2'd1);
        open_d  = 1'b1;
      end
    end
  end

endmodule

### sv/tls_queue.sv
// ----------------------------------------------------------------------------
// tls_queue: command FIFO
// Small FIFO between classifier and result sequencer.
// ----------------------------------------------------------------------------
module tls_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tls_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output tls_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  tls_pkg::cmd_t                 mem_q [tls_pkg::QUEUE_DEPTH];
  logic [tls_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [tls_pkg::QPTR_BITS:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (tls_pkg::QPTR_BITS+1)'(tls_pkg::QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### sv/tls_back.sv
// ----------------------------------------------------------------------------
// tls_back: result sequencer
// Walks the result slots of the head command, one result per cycle unless the output is stalled.
// ----------------------------------------------------------------------------
module tls_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tls_pkg::cmd_t                 head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  logic [tls_pkg::UNIT_BITS-1:0] cr_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output tls_pkg::result_t              res_o
);

  logic              ov_q, ov_d;
  logic [1:0]        idx_q, idx_d;
  logic              load, slot_last;
  tls_pkg::kind_e    kind;
  tls_pkg::result_t  res_q, res_d;

  assign valid_o = ov_q;
  assign res_o   = res_q;

  assign load      = !empty_i && (!ov_q || ready_i);
  assign slot_last = (idx_q == head_i.cnt - 2'd1);
  assign pop_o     = load && slot_last;

  always_comb begin
    case (idx_q)
      2'd0:    kind = head_i.kind[0];
      2'd1:    kind = head_i.kind[1];
      default: kind = head_i.kind[2];
    endcase

    res_d            = '0;
    res_d.last       = slot_last;
    res_d.stream_end = slot_last && head_i.eos;
    case (kind)
      tls_pkg::K_CR: begin
        res_d.has_unit = 1'b1;
        res_d.unit     = cr_i;
      end
      tls_pkg::K_CR_END: begin
        res_d.has_unit = 1'b1;
        res_d.unit     = cr_i;
        res_d.line_end = 1'b1;
        res_d.len      = head_i.len;
      end
      tls_pkg::K_CR_END1: begin
        res_d.has_unit = 1'b1;
        res_d.unit     = cr_i;
        res_d.line_end = 1'b1;
        res_d.len      = tls_pkg::len_sat_add('0, 2'd1);
      end
      tls_pkg::K_UNIT: begin
        res_d.has_unit = 1'b1;
        res_d.unit     = head_i.unit;
      end
      tls_pkg::K_UNIT_END: begin
        res_d.has_unit = 1'b1;
        res_d.unit     = head_i.unit;
        res_d.line_end = 1'b1;
        res_d.len      = head_i.len;
      end
      tls_pkg::K_CLOSE: begin
        res_d.line_end = 1'b1;
        res_d.len      = head_i.len;
      end
      default: begin
      end
    endcase

    idx_d = idx_q;
    if (load) begin
      idx_d = slot_last ? 2'd0 : idx_q + 2'd1;
    end

    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      ov_q  <= ov_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

### sv/text_line_splitter.sv
// ----------------------------------------------------------------------------
// text_line_splitter: splits a stream of text code units into lines
// Top level: config registers, classifier, command FIFO, result sequencer.
// ----------------------------------------------------------------------------
// Takes one input item per cycle while the command FIFO is not full. Each
// unit item yields zero to three results (a CR is held until the next item
// decides LF, CR CR LF or lone CR), and the output side issues one result per
// cycle unless the output is stalled; a 4-entry command FIFO lets the input
// keep going meanwhile. An item with results is written into the FIFO and then
// loaded into the output register before its first result shows. End-of-stream
// items flush held CRs or the open line and return all line state to reset.
// Config (unit width, byte order) must be written only while idle; CR/LF codes
// follow it, units pass through unswapped, masked to the configured width.
// ----------------------------------------------------------------------------
module text_line_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port: index 0 = unit_bytes, 1 = big_endian
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] code_unit
  input  logic [0:0]  s_axis_tuser,   // [0] action (1 = end of stream)
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] out_unit, [47:32] line_length
  output logic [2:0]  m_axis_tuser,   // [0] has_unit, [1] line_end, [2] stream_end
  output logic        m_axis_tlast    // last result of this item
);

  logic [tls_pkg::CFG_BITS-1:0] unit_bytes_q;
  logic                         big_endian_q;
  tls_pkg::match_t              match;

  logic             push, pop, empty, full;
  tls_pkg::cmd_t    cmd, head;
  tls_pkg::result_t res;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_bytes_q <= 3'd1;
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tls_pkg::CFG_UNIT_BYTES: unit_bytes_q <= cfg_data_i;
        tls_pkg::CFG_BIG_ENDIAN: big_endian_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // CR/LF codes and unit mask for the current width and byte order
  always_comb begin
    match.unit_mask = tls_pkg::unit_mask(unit_bytes_q);
    match.cr        = tls_pkg::char_code(unit_bytes_q, big_endian_q, tls_pkg::CH_CR);
    match.lf        = tls_pkg::char_code(unit_bytes_q, big_endian_q, tls_pkg::CH_LF);
  end

  // Front: classify each item into a command of up to three results
  tls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .action_i    (s_axis_tuser[0]),
    .code_unit_i (s_axis_tdata),
    .match_i     (match),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  // Decoupling FIFO; commands with no result are never pushed
  tls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  // Back: one result per cycle into the output register while the output is not stalled
  tls_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .cr_i    (match.cr),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {res.len, res.unit};
  assign m_axis_tuser = {res.stream_end, res.line_end, res.has_unit};
  assign m_axis_tlast = res.last;

endmodule

### bench/text_line_splitter_tb.sv
// ----------------------------------------------------------------------------
// text_line_splitter_tb: self-checking bench for the text line splitter
// Drives code units and end-of-stream items into the input stream, predicts
// each line unit, line end and length in a local model of the splitter, and
// compares every output item against the oldest prediction. Both stream sides
// idle at random; one phase holds the output off while the input keeps offering.
// ----------------------------------------------------------------------------
module text_line_splitter_tb;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int DRAIN_TAIL  = 8;      // cycles after the last result, > latency
  localparam int HOLD_CYCLES = 120;    // long output hold-off

  // DUT ports, all inputs known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_index_i   = '0;
  logic [2:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  text_line_splitter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] code_unit
    .s_axis_tuser  (s_axis_tuser),   // [0] action (1 = end of stream)
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] out_unit, [47:32] line_length
    .m_axis_tuser  (m_axis_tuser),   // [0] has_unit, [1] line_end, [2] stream_end
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Local model of the splitter: register copies and line state
  // --------------------------------------------------------------------------
  logic [2:0]       cfg_unit_bytes = 3'd1;
  logic             cfg_big_endian = 1'b0;
  tls_pkg::phase_e  held_crs       = tls_pkg::PH_NONE;  // CRs held back, not yet echoed
  logic [15:0]      units_in_line  = '0;                // echoed units of the open line
  logic             line_is_open   = 1'b0;

  tls_pkg::result_t line_items_q[$];       // predicted output items, oldest first
  tls_pkg::result_t staged;                // newest prediction, waits for tlast
  bit               have_staged = 0;

  // run bookkeeping
  int          mismatches    = 0;
  int          items_sent    = 0;
  int          items_checked = 0;
  int          settings_used = 0;
  int          cycles        = 0;

  // idle shaping
  bit          tx_jitter = 1;
  bit          rx_jitter = 1;
  logic        hold_off  = 1'b0;
  int          rx_stall  = 0;
  int          rx_roll;

  // Effective unit width: only 1 and 2 stand as given, the rest mean 4 bytes.
  function automatic int unit_width();
    return (cfg_unit_bytes == 3'd1 || cfg_unit_bytes == 3'd2) ? int'(cfg_unit_bytes) : 4;
  endfunction

  function automatic logic [31:0] width_mask();
    return (unit_width() == 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * unit_width())) - 32'h1;
  endfunction

  // CR/LF as they appear in a unit of the current width and byte order
  function automatic logic [31:0] code_of_char(logic [7:0] ch);
    return {24'h0, ch} << (cfg_big_endian ? 8 * (unit_width() - 1) : 0);
  endfunction

  function automatic logic [15:0] capped_len(logic [15:0] count, int extra);
    int total;
    total = int'(count) + extra;
    return (total > 32'hFFFF) ? 16'hFFFF : 16'(total);
  endfunction

  // Queue one predicted item; the previous one is final once another follows.
  task automatic emit(logic has, logic [31:0] unit, logic ends, logic [15:0] len);
    if (have_staged) line_items_q.push_back(staged);
    staged.has_unit   = has;
    staged.unit       = unit;
    staged.line_end   = ends;
    staged.len        = len;
    staged.stream_end = 1'b0;
    staged.last       = 1'b0;
    have_staged       = 1;
  endtask

  task automatic close_state();
    held_crs      = tls_pkg::PH_NONE;
    units_in_line = '0;
    line_is_open  = 1'b0;
  endtask

  // Predict the output items caused by one accepted input item.
  task automatic split_into_lines(logic eos, logic [31:0] raw);
    logic [31:0] cr;
    logic [31:0] lf;
    logic [31:0] u;
    logic        is_cr;
    logic        is_lf;
    int          held;
    cr    = code_of_char(tls_pkg::CH_CR);
    lf    = code_of_char(tls_pkg::CH_LF);
    u     = raw & width_mask();
    is_cr = (u == cr);
    is_lf = (u == lf);
    held  = (held_crs == tls_pkg::PH_CRCR) ? 2 : (held_crs == tls_pkg::PH_CR) ? 1 : 0;

    if (eos) begin
      // flush held CRs as line ends, or close an open line without a unit
      if (held != 0) begin
        emit(1'b1, cr, 1'b1, capped_len(units_in_line, 1));
        if (held == 2) emit(1'b1, cr, 1'b1, 16'd1);
      end else if (line_is_open) begin
        emit(1'b0, '0, 1'b1, units_in_line);
      end
      if (!have_staged) emit(1'b0, '0, 1'b0, '0);
      staged.stream_end = 1'b1;
      close_state();
    end else if (held == 0) begin
      if (is_lf) begin
        emit(1'b1, u, 1'b1, capped_len(units_in_line, 1));
        close_state();
      end else if (is_cr) begin
        held_crs = tls_pkg::PH_CR;
      end else begin
        emit(1'b1, u, 1'b0, '0);
        units_in_line = capped_len(units_in_line, 1);
        line_is_open  = 1'b1;
      end
    end else if (is_lf) begin
      // CR LF or CR CR LF: the CRs are echoed inside the line, LF closes it
      emit(1'b1, cr, 1'b0, '0);
      if (held == 2) emit(1'b1, cr, 1'b0, '0);
      emit(1'b1, u, 1'b1, capped_len(units_in_line, held + 1));
      close_state();
    end else if (is_cr && held == 1) begin
      held_crs = tls_pkg::PH_CRCR;
    end else begin
      // held CRs each end a line; a new CR is held, a plain unit opens a line
      emit(1'b1, cr, 1'b1, capped_len(units_in_line, 1));
      if (held == 2) emit(1'b1, cr, 1'b1, 16'd1);
      close_state();
      if (is_cr) begin
        held_crs = tls_pkg::PH_CR;
      end else begin
        emit(1'b1, u, 1'b0, '0);
        units_in_line = 16'd1;
        line_is_open  = 1'b1;
      end
    end

    if (have_staged) begin
      staged.last = 1'b1;
      line_items_q.push_back(staged);
      have_staged = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready pattern and checker
  // --------------------------------------------------------------------------
  // Mostly ready, short stalls, now and then a long one; hold_off wins.
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall      <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_jitter) begin
      m_axis_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_stall      <= (rx_roll < 97) ? $urandom_range(0, 2) : $urandom_range(6, 30);
      end
    end
  end

  task automatic report(string what, tls_pkg::result_t want, tls_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: expected has=%0b unit=%h end=%0b len=%0d eos=%0b last=%0b",
               what, want.has_unit, want.unit, want.line_end, want.len, want.stream_end,
               want.last);
      $display("  got has=%0b unit=%h end=%0b len=%0d eos=%0b last=%0b",
               got.has_unit, got.unit, got.line_end, got.len, got.stream_end, got.last);
    end
  endtask

  tls_pkg::result_t seen;
  tls_pkg::result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.has_unit   = m_axis_tuser[0];
      seen.unit       = m_axis_tdata[31:0];
      seen.line_end   = m_axis_tuser[1];
      seen.len        = m_axis_tdata[47:32];
      seen.stream_end = m_axis_tuser[2];
      seen.last       = m_axis_tlast;
      items_checked++;
      if (line_items_q.size() == 0) begin
        want = '0;
        report("unexpected item", want, seen);
      end else begin
        want = line_items_q.pop_front();
        if (seen !== want) report("field", want, seen);
      end
    end
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d items still expected",
               cycles, line_items_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_jitter || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Offer one item, hold it until accepted, then maybe idle a while.
  task automatic send_item(logic eos, logic [31:0] unit);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= unit;
    s_axis_tuser  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    split_into_lines(eos, unit);
    items_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_unit(logic [31:0] unit);
    send_item(1'b0, unit);
  endtask

  task automatic send_eos();
    send_item(1'b1, $urandom);
  endtask

  // Drain everything, then give the block time to finish any silent item.
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (line_items_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // Both registers, one per cycle; only called while idle.
  task automatic set_config(logic [2:0] ub, logic be);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= tls_pkg::CFG_UNIT_BYTES;
    cfg_data_i  <= ub;
    @(posedge clk_i);
    cfg_unit_bytes = ub;
    cfg_index_i <= tls_pkg::CFG_BIG_ENDIAN;
    cfg_data_i  <= {2'b00, be};
    @(posedge clk_i);
    cfg_big_endian = be;
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Random unit, biased toward CR/LF so that real line endings are common.
  function automatic logic [31:0] text_unit();
    int          r;
    logic [31:0] junk;
    r    = $urandom_range(0, 99);
    junk = $urandom & ~width_mask();   // bits above the unit width are ignored
    if (r < 25) return code_of_char(tls_pkg::CH_CR) | junk;
    if (r < 45) return code_of_char(tls_pkg::CH_LF) | junk;
    if (r < 52) return (r[0] ? 32'h0000_000D : 32'h0A00_0000) << (8 * $urandom_range(0, 3));
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every ending form at reset settings (8-bit units, little endian).
  task automatic test_line_endings();
    send_unit(32'h0A);                                       // empty LF line
    send_unit(32'h61); send_unit(32'h62); send_unit(32'h0A);
    send_unit(32'h63); send_unit(32'h0D); send_unit(32'h0A); // CR LF
    send_unit(32'h0D); send_unit(32'h0D); send_unit(32'h0A); // CR CR LF
    send_unit(32'h78); send_unit(32'h0D); send_unit(32'h79); // lone CR, then text
    send_unit(32'h0D); send_unit(32'h0D); send_unit(32'h7A); // CR CR then text
    send_unit(32'h0D); send_unit(32'h0D); send_unit(32'h0D); send_unit(32'h0A);
    send_unit(32'hFFFF_FF0D); send_eos();                    // masked CR, flushed
    send_unit(32'h0D); send_unit(32'h0D); send_eos();        // two CRs flushed
    send_unit(32'h0000_0000); send_unit(32'hFFFF_FFFF); send_eos(); // open line
    send_eos();                                              // nothing pending
  endtask

  // Each width and byte order, the odd width codes among them.
  task automatic test_unit_widths();
    logic [2:0] ub_list[11] = '{3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd4, 3'd0, 3'd3,
                                3'd5, 3'd6, 3'd7};
    logic       be_list[11] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                                1'b1, 1'b0, 1'b1};
    for (int i = 0; i < 11; i++) begin
      set_config(ub_list[i], be_list[i]);
      send_unit(32'h0000_0041);
      send_unit(code_of_char(tls_pkg::CH_CR));
      send_unit(code_of_char(tls_pkg::CH_LF));
      send_unit(32'h0D00_000D);                // CR byte at both ends
      send_unit(code_of_char(tls_pkg::CH_CR) | (32'hFFFF_FFFF & ~width_mask()));
      send_unit(32'hFFFF_FFFF);
      send_unit(32'h0A00_0A0A);
      send_unit(code_of_char(tls_pkg::CH_CR));
      send_eos();
    end
  endtask

  // A held CR survives a register change and is then echoed in the new format.
  task automatic test_held_cr_across_config();
    set_config(3'd1, 1'b0);
    send_unit(32'h0000_0051);
    send_unit(32'h0000_000D);
    set_config(3'd2, 1'b1);
    send_unit(code_of_char(tls_pkg::CH_LF));
    send_unit(32'h0000_000D);                  // plain unit in big-endian 16-bit
    send_unit(code_of_char(tls_pkg::CH_CR));
    set_config(3'd4, 1'b0);
    send_eos();
  endtask

  // Random text over random settings.
  task automatic test_random_text();
    for (int p = 0; p < 3; p++) begin
      set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 99) < 4) send_eos();
        else send_unit(text_unit());
      end
      send_eos();
    end
  endtask

  // Output held off while the input keeps offering: the command FIFO fills up.
  task automatic test_backpressure();
    set_config(3'd2, 1'b0);
    tx_jitter = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        for (int i = 0; i < 30; i++) send_unit((i % 5 == 4) ? text_unit() : $urandom);
        send_eos();
      end
    join
    tx_jitter = 1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_line_endings();
    test_unit_widths();
    test_held_cr_across_config();
    test_random_text();
    test_backpressure();

    settle_idle();
    $display("Sent %0d items over %0d register settings, checked %0d output items;",
             items_sent, settings_used, items_checked);
    $display("covered LF, CR LF, CR CR LF, lone CR, flushes, held CR across config.");
    if (mismatches == 0 && line_items_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d items never seen", mismatches, line_items_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
